// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the slot scheduler. Every form is clocked on clk
// and is switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one on the next edge.
`define RRS_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// File: sv/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Sizes, request and result types and helper functions of the round-robin
// slot scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // Number of job slots and width of a tick count.
  localparam int SLOTS      = 16;
  localparam int TICK_BITS  = 16;

  // Derived widths.
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int LEN_W      = 16;
  localparam int QNT_W      = 16;
  localparam int SLOT_OUT_W = 4;

  localparam logic [QNT_W-1:0] QUANTUM_RST = QNT_W'(10);
  localparam logic [31:0]      TICK_MAX    = 32'((64'(1) << TICK_BITS) - 64'(1));

  // Request command codes.
  typedef enum logic {
    CMD_CREATE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  // One request as held in the input register.
  typedef struct packed {
    logic             command;
    logic [LEN_W-1:0] job_ticks;
  } item_t;

  // One result as held in the output register.
  typedef struct packed {
    logic                  create_ok;
    logic [SLOT_OUT_W-1:0] created_slot;
    logic                  running_valid;
    logic [SLOT_OUT_W-1:0] running_slot;
    logic                  switched;
    logic                  finished_valid;
    logic [SLOT_OUT_W-1:0] finished_slot;
  } result_t;

  // A ready queue entry: the slot and the ticks it still has to run.
  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic [TICK_BITS-1:0] ticks;
  } entry_t;

  // Ready queue control from the scheduler.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wr_entry;
  } q_ctl_t;

  // Ready queue status to the scheduler.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    entry_t           head;
  } q_stat_t;

  // Clamp a job length to the tick range.
  function automatic logic [TICK_BITS-1:0] sat_len(input logic [LEN_W-1:0] len);
    logic [31:0] wide;
    wide = 32'(len);
    if (wide > TICK_MAX) begin
      wide = TICK_MAX;
    end
    return wide[TICK_BITS-1:0];
  endfunction

  // Slice loaded on dispatch: min(quantum, remaining), a zero quantum acting as one.
  function automatic logic [TICK_BITS-1:0] first_slice(input logic [QNT_W-1:0] q,
                                                       input logic [TICK_BITS-1:0] rem);
    logic [QNT_W-1:0] q_eff;
    q_eff = (q == '0) ? QNT_W'(1) : q;
    if (32'(q_eff) < 32'(rem)) begin
      return TICK_BITS'(q_eff);
    end
    return rem;
  endfunction

endpackage

// File: sv/rrs_in_if.sv
// ----------------------------------------------------------------------------
// rrs_in_if
// Request channel of the slot scheduler: command and job length.
// ----------------------------------------------------------------------------
interface rrs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] job_ticks;

  modport source (output valid, output command, output job_ticks, input ready);
  modport sink   (input valid, input command, input job_ticks, output ready);
endinterface

// File: sv/rrs_out_if.sv
// ----------------------------------------------------------------------------
// rrs_out_if
// Result channel of the slot scheduler: create, dispatch and finish report.
// ----------------------------------------------------------------------------
interface rrs_out_if;
  logic       valid;
  logic       ready;
  logic       create_ok;
  logic [3:0] created_slot;
  logic       running_valid;
  logic [3:0] running_slot;
  logic       switched;
  logic       finished_valid;
  logic [3:0] finished_slot;

  modport source (output valid, output create_ok, output created_slot,
                  output running_valid, output running_slot, output switched,
                  output finished_valid, output finished_slot, input ready);
  modport sink   (input valid, input create_ok, input created_slot,
                  input running_valid, input running_slot, input switched,
                  input finished_valid, input finished_slot, output ready);
endinterface

// File: sv/rrs_cfg_if.sv
// ----------------------------------------------------------------------------
// rrs_cfg_if
// Configuration write channel of the slot scheduler: the time quantum.
// ----------------------------------------------------------------------------
interface rrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] quantum;

  modport source (output valid, output quantum, input ready);
  modport sink   (input valid, input quantum, output ready);
endinterface

// File: sv/rrs_ready_queue.sv
// ----------------------------------------------------------------------------
// rrs_ready_queue
// Circular ready queue of slot entries with their remaining ticks. One push
// and one pop per cycle; the head entry is visible combinationally.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrs_ready_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  rrs_pkg::q_ctl_t q_ctl,
  output rrs_pkg::q_stat_t q_stat
);
  import rrs_pkg::*;

  entry_t            entries_r [SLOTS];
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Wrap a queue pointer at the slot count.
  function automatic logic [SLOT_W-1:0] ptr_inc(input logic [SLOT_W-1:0] p);
    return (32'(p) == SLOTS - 1) ? '0 : p + SLOT_W'(1);
  endfunction

  // Pointer and count update.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (q_ctl.push) begin
      tail_nxt = ptr_inc(tail_r);
    end
    if (q_ctl.pop) begin
      head_nxt = ptr_inc(head_r);
    end
    if (q_ctl.push && !q_ctl.pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (q_ctl.pop && !q_ctl.push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage, written at the tail.
  always_ff @(posedge clk) begin
    if (q_ctl.push) begin
      entries_r[tail_r] <= q_ctl.wr_entry;
    end
  end

  assign q_stat.count = count_r;
  assign q_stat.head  = entries_r[head_r];

  // The queue never holds more entries than there are slots.
  `RRS_ASSERT(a_count_range, 32'(count_r) <= SLOTS, "ready queue count beyond slot count")

endmodule

// File: sv/rrs_slot_sched.sv
// ----------------------------------------------------------------------------
// rrs_slot_sched
// Scheduling step: slot allocation, tick accounting, requeue and dispatch.
// Computes one result per request and updates the slot and running state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrs_slot_sched (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  rrs_pkg::item_t                  item,
  input  logic [rrs_pkg::QNT_W-1:0]       quantum,
  input  rrs_pkg::q_stat_t                q_stat,
  output rrs_pkg::q_ctl_t                 q_ctl,
  output rrs_pkg::result_t                result
);
  import rrs_pkg::*;

  logic [SLOTS-1:0]     busy_r, busy_nxt;
  logic                 cur_valid_r, cur_valid_nxt;
  logic [SLOT_W-1:0]    cur_slot_r, cur_slot_nxt;
  logic [TICK_BITS-1:0] cur_rem_r, cur_rem_nxt;
  logic [TICK_BITS-1:0] slice_r, slice_nxt;

  logic                 free_any;
  logic [SLOT_W-1:0]    free_idx;
  logic [TICK_BITS-1:0] len_sat;
  logic [TICK_BITS-1:0] rem_dec;
  logic [TICK_BITS-1:0] slice_dec;
  logic                 ready_none;
  int                   live_jobs;
  logic                 run_ticks_ok;

  // Lowest free slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign len_sat     = sat_len(item.job_ticks);
  assign rem_dec     = (cur_rem_r != '0) ? cur_rem_r - TICK_BITS'(1) : '0;
  assign slice_dec   = (slice_r != '0) ? slice_r - TICK_BITS'(1) : '0;
  assign ready_none  = (q_stat.count == '0);

  // One scheduling step.
  always_comb begin
    busy_nxt      = busy_r;
    cur_valid_nxt = cur_valid_r;
    cur_slot_nxt  = cur_slot_r;
    cur_rem_nxt   = cur_rem_r;
    slice_nxt     = slice_r;
    q_ctl         = '0;
    result        = '0;

    if (go) begin
      if (item.command == CMD_CREATE) begin
        // Create: take the lowest free slot and queue it.
        if (len_sat != '0 && free_any) begin
          busy_nxt[free_idx]    = 1'b1;
          q_ctl.push            = 1'b1;
          q_ctl.wr_entry.slot   = free_idx;
          q_ctl.wr_entry.ticks  = len_sat;
          result.create_ok      = 1'b1;
          result.created_slot   = SLOT_OUT_W'(free_idx);
        end
      end else if (!cur_valid_r) begin
        // Tick while idle: dispatch the head without charging it.
        if (!ready_none) begin
          q_ctl.pop       = 1'b1;
          cur_valid_nxt   = 1'b1;
          cur_slot_nxt    = q_stat.head.slot;
          cur_rem_nxt     = q_stat.head.ticks;
          slice_nxt       = first_slice(quantum, q_stat.head.ticks);
          result.switched = 1'b1;
        end
      end else if (rem_dec == '0) begin
        // The running job is done: free its slot and dispatch the head.
        busy_nxt[cur_slot_r]  = 1'b0;
        result.finished_valid = 1'b1;
        result.finished_slot  = SLOT_OUT_W'(cur_slot_r);
        if (!ready_none) begin
          q_ctl.pop       = 1'b1;
          cur_valid_nxt   = 1'b1;
          cur_slot_nxt    = q_stat.head.slot;
          cur_rem_nxt     = q_stat.head.ticks;
          slice_nxt       = first_slice(quantum, q_stat.head.ticks);
          result.switched = 1'b1;
        end else begin
          cur_valid_nxt = 1'b0;
          cur_slot_nxt  = '0;
          cur_rem_nxt   = '0;
          slice_nxt     = '0;
        end
      end else if (slice_dec == '0) begin
        // Slice expired: requeue the job and dispatch the head.
        result.switched = 1'b1;
        if (!ready_none) begin
          q_ctl.push           = 1'b1;
          q_ctl.wr_entry.slot  = cur_slot_r;
          q_ctl.wr_entry.ticks = rem_dec;
          q_ctl.pop            = 1'b1;
          cur_slot_nxt         = q_stat.head.slot;
          cur_rem_nxt          = q_stat.head.ticks;
          slice_nxt            = first_slice(quantum, q_stat.head.ticks);
        end else begin
          // Alone in the system: the same job comes straight back.
          cur_rem_nxt = rem_dec;
          slice_nxt   = first_slice(quantum, rem_dec);
        end
      end else begin
        cur_rem_nxt = rem_dec;
        slice_nxt   = slice_dec;
      end

      result.running_valid = cur_valid_nxt;
      result.running_slot  = cur_valid_nxt ? SLOT_OUT_W'(cur_slot_nxt) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      cur_valid_r <= 1'b0;
      cur_slot_r  <= '0;
      cur_rem_r   <= '0;
      slice_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_rem_r   <= cur_rem_nxt;
      slice_r     <= slice_nxt;
    end
  end

  // Jobs held by the queue and the running position, and the running job's counters.
  assign live_jobs    = int'(q_stat.count) + int'(cur_valid_r);
  assign run_ticks_ok = (cur_rem_r != '0) && (slice_r != '0) && (slice_r <= cur_rem_r);

  // Every busy slot is either running or waiting in the queue.
  `RRS_ASSERT(a_busy_balance, $countones(busy_r) == live_jobs, "busy slots differ from live jobs")
  // A running job holds a busy slot.
  `RRS_ASSERT(a_run_busy, !cur_valid_r || busy_r[cur_slot_r], "running job on a free slot")
  // A running job always has ticks and slice left.
  `RRS_ASSERT(a_run_ticks, !cur_valid_r || run_ticks_ok, "running job without ticks or slice")

endmodule

// File: sv/round_robin_slot_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_slot_scheduler_core
// Round-robin time-slice scheduler over job slots: creates jobs in the lowest
// free slot, charges timer ticks to the running job and rotates the ready
// queue on finish or slice expiry.
//
//   Channel  Dir  Handshake      Request content
//   in_ch    in   valid/ready    command, job_ticks
//   out_ch   out  valid/ready    create/running/switch/finish report
//   cfg_ch   in   valid/ready    quantum (reset 10)
//
// A request is held in the input register and its result is registered in
// the output register when the step runs; a new request is taken every cycle
// unless the output stalls. The whole step is one pass of the slot encoder
// and queue update in rrs_slot_sched. When the output is stalled the input
// register holds its request and in_ch.ready drops. Reset is synchronous and
// clears all control state; the quantum register is always ready.
// ----------------------------------------------------------------------------
module round_robin_slot_scheduler_core (
  input  logic       clk,
  input  logic       rst_n,
  rrs_in_if.sink     in_ch,
  rrs_out_if.source  out_ch,
  rrs_cfg_if.sink    cfg_ch
);
  import rrs_pkg::*;

  logic             in_vld_r, in_vld_nxt;
  item_t            in_item_r;
  logic             out_vld_r, out_vld_nxt;
  result_t          out_res_r;
  logic [QNT_W-1:0] quantum_r;
  logic             go;
  logic             in_take;
  result_t          step_res;
  q_ctl_t           q_ctl;
  q_stat_t          q_stat;

  // Handshake: the step runs when a request is held and the output can take it.
  assign go          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || go;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (go) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control registers and the quantum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      quantum_r <= QUANTUM_RST;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        quantum_r <= cfg_ch.quantum;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.command   <= in_ch.command;
      in_item_r.job_ticks <= in_ch.job_ticks;
    end
    if (go) begin
      out_res_r <= step_res;
    end
  end

  rrs_slot_sched u_sched (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .item    (in_item_r),
    .quantum (quantum_r),
    .q_stat  (q_stat),
    .q_ctl   (q_ctl),
    .result  (step_res)
  );

  rrs_ready_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_ctl  (q_ctl),
    .q_stat (q_stat)
  );

  // Result channel.
  assign out_ch.valid          = out_vld_r;
  assign out_ch.create_ok      = out_res_r.create_ok;
  assign out_ch.created_slot   = out_res_r.created_slot;
  assign out_ch.running_valid  = out_res_r.running_valid;
  assign out_ch.running_slot   = out_res_r.running_slot;
  assign out_ch.switched       = out_res_r.switched;
  assign out_ch.finished_valid = out_res_r.finished_valid;
  assign out_ch.finished_slot  = out_res_r.finished_slot;

endmodule
